>>> hdl/hmap_pkg.sv
// Shared types and constants for the chained hash map.
// No dependencies.
package hmap_pkg;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 7;
	localparam int BUCKETS = 64;
	localparam int BKT_W   = 6;
	localparam int NODES   = 256;
	localparam int NODE_W  = 8;
	localparam int LINK_W  = 9;
	localparam int STEPS   = 4;

	localparam logic [CNT_W-1:0] BUCKETS_C = CNT_W'(BUCKETS);
	localparam logic [LINK_W-1:0] NODES_C = LINK_W'(NODES);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [BKT_W-1:0] bucket;
	} job_t;

	typedef struct packed {
		logic [LINK_W-1:0] head;
		logic [LINK_W-1:0] tail;
	} bucket_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_HEAD,
		BS_LINK,
		BS_CMP
	} back_state_t;
endpackage

>>> hdl/hmap_front.sv
// Front end: accepts commands and reduces the key modulo the bucket count
// (clamped to 1..BUCKETS), four bits per cycle. Depends on hmap_pkg.
module hmap_front import hmap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             in_cmd,
	input  logic [KEY_W-1:0] in_key,
	input  logic [VAL_W-1:0] in_value,
	input  logic [CNT_W-1:0] bucket_count,
	output logic             job_valid,
	input  logic             job_ready,
	output job_t             job
);
	localparam int ROUNDS = KEY_W / STEPS;

	logic busy_q, done_q;
	logic [$clog2(ROUNDS)-1:0] cnt_q;
	logic [KEY_W-1:0] shift_q;
	logic [CNT_W-1:0] rem_q, rem_next, div;
	job_t job_q;

	always_comb begin
		if (bucket_count == '0)
			div = CNT_W'(1);
		else if (bucket_count > BUCKETS_C)
			div = BUCKETS_C;
		else
			div = bucket_count;
	end

	always_comb begin
		logic [CNT_W-1:0] t;
		rem_next = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {rem_next[CNT_W-2:0], shift_q[KEY_W-1-i]};
			rem_next = (t >= div) ? t - div : t;
		end
	end

	assign in_ready  = !busy_q && !done_q;
	assign job_valid = done_q;
	always_comb begin
		job = job_q;
		job.bucket = rem_q[BKT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $bits(cnt_q)'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q && job_ready) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			shift_q      <= in_key;
			rem_q        <= '0;
			job_q.cmd    <= in_cmd;
			job_q.key    <= in_key;
			job_q.value  <= in_value;
			job_q.bucket <= '0;
		end else if (busy_q) begin
			shift_q <= shift_q << STEPS;
			rem_q   <= rem_next;
		end
	end
endmodule

>>> hdl/hmap_fifo.sv
// Two-entry job queue between front and back end.
// Depends on hmap_pkg.
module hmap_fifo import hmap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  job_t din,
	input  logic pop,
	output logic nonempty,
	output job_t dout
);
	job_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'd2;
	assign nonempty = count_q != 2'd0;
	assign dout     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push && !full) wr_q <= !wr_q;
			if (pop && nonempty) rd_q <= !rd_q;
			count_q <= count_q + 2'((push && !full) ? 1 : 0) - 2'((pop && nonempty) ? 1 : 0);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= din;
	end
endmodule

>>> hdl/hmap_back.sv
// Back end: bucket table, node pool and chain walk, plus the result register.
// Depends on hmap_pkg.
module hmap_back import hmap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	output logic             job_pop,
	input  job_t             job,
	output logic             out_valid,
	input  logic             out_ready,
	output status_t          out_status,
	output logic [VAL_W-1:0] out_value
);
	bucket_t          bkt_mem [BUCKETS];
	logic [BUCKETS-1:0] bkt_vld_q;
	logic [KEY_W-1:0] key_mem [NODES];
	logic [VAL_W-1:0] val_mem [NODES];
	logic [LINK_W-1:0] link_mem [NODES];

	back_state_t state_q, state_d;
	job_t job_q;
	logic [LINK_W-1:0] used_q, used_d, fix_addr_q, fix_addr_d, fix_data_q, fix_data_d;

	bucket_t bkt_rd_q, bkt_wdata;
	logic bkt_hit_q, bkt_we;
	logic [LINK_W-1:0] head, tail, n1;
	logic [NODE_W-1:0] node_raddr, link_waddr;
	logic [KEY_W-1:0] key_rd_q;
	logic [VAL_W-1:0] val_rd_q;
	logic [LINK_W-1:0] link_rd_q, link_wdata;
	logic node_we, link_we;

	logic res_fire;
	status_t res_status;
	logic [VAL_W-1:0] res_value;

	assign head = bkt_hit_q ? bkt_rd_q.head : '0;
	assign tail = bkt_hit_q ? bkt_rd_q.tail : '0;
	assign n1   = used_q + 1'b1;

	always_comb begin
		state_d    = state_q;
		used_d     = used_q;
		fix_addr_d = fix_addr_q;
		fix_data_d = fix_data_q;
		job_pop    = 1'b0;
		node_raddr = '0;
		node_we    = 1'b0;
		link_we    = 1'b0;
		link_waddr = used_q[NODE_W-1:0];
		link_wdata = '0;
		bkt_we     = 1'b0;
		bkt_wdata  = '{head: n1, tail: n1};
		res_fire   = 1'b0;
		res_status = ST_OK;
		res_value  = '0;
		unique case (state_q)
			BS_IDLE: begin
				if (job_valid && !out_valid) begin
					job_pop = 1'b1;
					state_d = BS_HEAD;
				end
			end
			BS_HEAD: begin
				if (job_q.cmd == CMD_INSERT) begin
					if (used_q == NODES_C) begin
						res_fire   = 1'b1;
						res_status = ST_FULL;
						state_d    = BS_IDLE;
					end else begin
						node_we = 1'b1;
						link_we = 1'b1;
						bkt_we  = 1'b1;
						used_d  = n1;
						if (head != '0) begin
							bkt_wdata  = '{head: head, tail: n1};
							fix_addr_d = tail - 1'b1;
							fix_data_d = n1;
							state_d    = BS_LINK;
						end else begin
							res_fire = 1'b1;
							state_d  = BS_IDLE;
						end
					end
				end else if (head == '0) begin
					res_fire   = 1'b1;
					res_status = ST_NOTFOUND;
					state_d    = BS_IDLE;
				end else begin
					node_raddr = NODE_W'(head - 1'b1);
					state_d    = BS_CMP;
				end
			end
			BS_LINK: begin
				link_we    = 1'b1;
				link_waddr = fix_addr_q[NODE_W-1:0];
				link_wdata = fix_data_q;
				res_fire   = 1'b1;
				state_d    = BS_IDLE;
			end
			BS_CMP: begin
				if (key_rd_q == job_q.key) begin
					res_fire  = 1'b1;
					res_value = val_rd_q;
					state_d   = BS_IDLE;
				end else if (link_rd_q == '0) begin
					res_fire   = 1'b1;
					res_status = ST_NOTFOUND;
					state_d    = BS_IDLE;
				end else begin
					node_raddr = NODE_W'(link_rd_q - 1'b1);
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BS_IDLE;
			used_q    <= '0;
			bkt_vld_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			if (bkt_we) bkt_vld_q[job_q.bucket] <= 1'b1;
			if (res_fire) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		fix_addr_q <= fix_addr_d;
		fix_data_q <= fix_data_d;
		if (job_pop) job_q <= job;
		bkt_rd_q  <= bkt_mem[job.bucket];
		bkt_hit_q <= bkt_vld_q[job.bucket];
		if (bkt_we) bkt_mem[job_q.bucket] <= bkt_wdata;
		key_rd_q  <= key_mem[node_raddr];
		val_rd_q  <= val_mem[node_raddr];
		link_rd_q <= link_mem[node_raddr];
		if (node_we) begin
			key_mem[used_q[NODE_W-1:0]] <= job_q.key;
			val_mem[used_q[NODE_W-1:0]] <= job_q.value;
		end
		if (link_we) link_mem[link_waddr] <= link_wdata;
		if (res_fire) begin
			out_status <= res_status;
			out_value  <= res_value;
		end
	end
endmodule

>>> hdl/chained_hash_map.sv
// Top level of the chained hash map: front end, job queue, back end.
// Depends on hmap_pkg, hmap_front, hmap_fifo, hmap_back.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: command; tdata: key, value
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: found_value
// cfg_*    in   cfg_valid/ready    cfg_data: bucket_count
//
// Front end: 32-bit key modulo (4 bits/cycle); it takes no new item until the
// current one is handed off. Back end: insert runs HEAD, and LINK when the
// bucket has a chain; lookup runs HEAD, then CMP at one chain node per cycle
// (one node memory read port). Queue of two decouples the ends.
// Reset clears bucket heads via per-bucket valid bits; no clearing pass.
// A pending result holds the back end; the front keeps taking items until the queue fills.
module chained_hash_map import hmap_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,  // key[31:0], value[63:32]
	input  logic             s_tuser,  // command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,  // found_value
	output logic [1:0]       m_tuser,  // status
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data  // bucket_count
);
	logic [CNT_W-1:0] bucket_count_q;
	logic f_valid, q_full, q_nonempty, q_pop;
	job_t f_job, q_job;
	status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_count_q <= BUCKETS_C;
		else if (cfg_valid) bucket_count_q <= cfg_data;
	end

	hmap_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_cmd(cmd_t'(s_tuser)), .in_key(s_tdata[31:0]), .in_value(s_tdata[63:32]),
		.bucket_count(bucket_count_q),
		.job_valid(f_valid), .job_ready(!q_full), .job(f_job)
	);

	hmap_fifo u_fifo (
		.clk, .arst_n,
		.push(f_valid), .full(q_full), .din(f_job),
		.pop(q_pop), .nonempty(q_nonempty), .dout(q_job)
	);

	hmap_back u_back (
		.clk, .arst_n,
		.job_valid(q_nonempty), .job_pop(q_pop), .job(q_job),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status(status), .out_value(m_tdata)
	);

	assign m_tuser = status;

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_FULL || m_tuser == ST_NOTFOUND))
		else $error("bad status code");
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("nonzero value with failing status");
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("front took a second item while reducing");
endmodule
